@@ sv/stream_find_replace_top_defines.svh @@
// Assertion macros shared by the find-and-replace block.
`ifndef STREAM_FIND_REPLACE_TOP_DEFINES_SVH
`define STREAM_FIND_REPLACE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define SFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define SFR_ASSERT_SAME(label, clk, rst, ante, cons)
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/sfr_pkg.sv @@
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int LEN_W      = 4;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FIND_PATTERN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIND_LENGTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_TEXT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LENGTH = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // append the accepted byte to the pending buffer
      logic clear;       // empty the pending buffer
      logic emit_buf;    // send the oldest pending byte and shift the buffer
      logic repl_start;  // rewind the replacement pointer
      logic emit_repl;   // send the next replacement byte
   } sfr_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic cnt_zero;    // pending buffer is empty
      logic pre_cur;     // pending bytes are a prefix of the pattern
      logic match_full;  // pending bytes are the whole pattern
      logic eos;         // current item carries end of stream
      logic rl_zero;     // replacement is empty
      logic repl_last;   // replacement pointer is on its final byte
      logic out_free;    // output register can take a beat this cycle
   } sfr_status_type;

endpackage

@@ sv/sfr_ctrl.sv @@
`timescale 1ns / 1ps

module sfr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sfr_pkg::sfr_status_type status,
   output sfr_pkg::sfr_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPL
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Sequence one item: load, then emit one beat per cycle while the output side has room
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.match_full) begin
               cmd.clear      = 1'b1;
               cmd.repl_start = 1'b1;
               state_in       = status.rl_zero ? ST_IDLE : ST_REPL;
            end else if (!status.cnt_zero && (!status.pre_cur || status.eos)) begin
               // drop the oldest byte out once the output side has room
               if (status.out_free) begin
                  cmd.emit_buf = 1'b1;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REPL: begin
            if (status.out_free) begin
               cmd.emit_repl = 1'b1;
               if (status.repl_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/sfr_datapath.sv @@
`timescale 1ns / 1ps

module sfr_datapath #(
   parameter int MAX_FIND_LENGTH    = 8,
   parameter int MAX_REPLACE_LENGTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [sfr_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                req_end_of_stream,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic                                rsp_last_in_run,
   input  sfr_pkg::sfr_cmd_type                cmd,
   output sfr_pkg::sfr_status_type             status
);

   localparam int CNT_W  = $clog2(MAX_FIND_LENGTH + 1);
   localparam int RLEN_W = $clog2(MAX_REPLACE_LENGTH + 1);
   localparam int RIDX_W = (MAX_REPLACE_LENGTH > 1) ? $clog2(MAX_REPLACE_LENGTH) : 1;
   localparam int BW     = sfr_pkg::BYTE_W;

   // Configuration registers
   logic [sfr_pkg::CSR_DATA_W-1:0] find_pattern_ff;
   logic [sfr_pkg::LEN_W-1:0]      find_length_ff;
   logic [sfr_pkg::CSR_DATA_W-1:0] replace_text_ff;
   logic [sfr_pkg::LEN_W-1:0]      replace_length_ff;

   // Pending buffer
   logic [BW-1:0]     buf_ff [MAX_FIND_LENGTH];
   logic [BW-1:0]     buf_in [MAX_FIND_LENGTH];
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              eos_ff;
   logic [RIDX_W-1:0] rep_idx_ff;

   // Output register
   logic          rsp_valid_ff;
   logic [BW-1:0] rsp_byte_ff;
   logic          rsp_last_ff;

   logic [CNT_W-1:0]  fl_eff;
   logic [RLEN_W-1:0] rl_eff;
   logic [CNT_W-1:0]  load_pos;
   logic              pre_cur;
   logic              pre_shift;
   logic              cnt_one;
   logic              repl_last;
   logic [BW-1:0]     repl_byte;
   logic              cfg_flush;

   // Clamp the configured lengths to the supported range
   always_comb begin
      if (find_length_ff == '0) begin
         fl_eff = CNT_W'(1);
      end else if (find_length_ff > sfr_pkg::LEN_W'(MAX_FIND_LENGTH)) begin
         fl_eff = CNT_W'(MAX_FIND_LENGTH);
      end else begin
         fl_eff = CNT_W'(find_length_ff);
      end
      if (replace_length_ff > sfr_pkg::LEN_W'(MAX_REPLACE_LENGTH)) begin
         rl_eff = RLEN_W'(MAX_REPLACE_LENGTH);
      end else begin
         rl_eff = RLEN_W'(replace_length_ff);
      end
   end

   assign load_pos = (cnt_ff >= fl_eff) ? (fl_eff - CNT_W'(1)) : cnt_ff;
   assign cnt_one  = (cnt_ff == CNT_W'(1));

   // Compare the buffer, as is and shifted by one, against the pattern
   always_comb begin
      pre_cur   = 1'b1;
      pre_shift = 1'b1;
      for (int j = 0; j < MAX_FIND_LENGTH; j++) begin
         if ((CNT_W'(j) < cnt_ff) && (buf_ff[j] != find_pattern_ff[BW*j +: BW])) begin
            pre_cur = 1'b0;
         end
      end
      for (int j = 0; j < MAX_FIND_LENGTH - 1; j++) begin
         if ((CNT_W'(j + 1) < cnt_ff) &&
             (buf_ff[j + 1] != find_pattern_ff[BW*j +: BW])) begin
            pre_shift = 1'b0;
         end
      end
   end

   // Pick the current replacement byte
   always_comb begin
      repl_byte = '0;
      for (int j = 0; j < MAX_REPLACE_LENGTH; j++) begin
         if (rep_idx_ff == RIDX_W'(j)) begin
            repl_byte = replace_text_ff[BW*j +: BW];
         end
      end
   end

   assign repl_last = ((RLEN_W'(rep_idx_ff) + RLEN_W'(1)) == rl_eff);

   // Next buffer contents: append on load, shift on emit, empty on clear or a pattern or length write
   always_comb begin
      for (int j = 0; j < MAX_FIND_LENGTH; j++) begin
         buf_in[j] = buf_ff[j];
      end
      cnt_in = cnt_ff;
      if (cmd.load) begin
         for (int j = 0; j < MAX_FIND_LENGTH; j++) begin
            if (load_pos == CNT_W'(j)) begin
               buf_in[j] = req_data_byte;
            end
         end
         cnt_in = load_pos + CNT_W'(1);
      end else if (cmd.emit_buf) begin
         for (int j = 0; j < MAX_FIND_LENGTH - 1; j++) begin
            buf_in[j] = buf_ff[j + 1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (cmd.clear || cfg_flush) begin
         cnt_in = '0;
      end
   end

   assign cfg_flush = csr_wen &&
                      ((csr_index == sfr_pkg::CSR_FIND_PATTERN) ||
                       (csr_index == sfr_pkg::CSR_FIND_LENGTH));

   // Hold configuration, buffer count and output valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         find_pattern_ff   <= '0;
         find_length_ff    <= sfr_pkg::LEN_W'(1);
         replace_text_ff   <= '0;
         replace_length_ff <= '0;
         cnt_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               sfr_pkg::CSR_FIND_PATTERN:   find_pattern_ff   <= csr_wdata;
               sfr_pkg::CSR_FIND_LENGTH:    find_length_ff    <= csr_wdata[sfr_pkg::LEN_W-1:0];
               sfr_pkg::CSR_REPLACE_TEXT:   replace_text_ff   <= csr_wdata;
               sfr_pkg::CSR_REPLACE_LENGTH: replace_length_ff <= csr_wdata[sfr_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
         cnt_ff <= cnt_in;
         if (cmd.emit_buf || cmd.emit_repl) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_FIND_LENGTH; j++) begin
         buf_ff[j] <= buf_in[j];
      end
      if (cmd.load) begin
         eos_ff <= req_end_of_stream;
      end
      if (cmd.repl_start) begin
         rep_idx_ff <= '0;
      end else if (cmd.emit_repl) begin
         rep_idx_ff <= rep_idx_ff + RIDX_W'(1);
      end
      if (cmd.emit_buf) begin
         rsp_byte_ff <= buf_ff[0];
         rsp_last_ff <= cnt_one || (pre_shift && !eos_ff);
      end else if (cmd.emit_repl) begin
         rsp_byte_ff <= repl_byte;
         rsp_last_ff <= repl_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_in_run = rsp_last_ff;

   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.pre_cur    = pre_cur;
   assign status.match_full = (cnt_ff == fl_eff) && pre_cur;
   assign status.eos        = eos_ff;
   assign status.rl_zero    = (rl_eff == '0);
   assign status.repl_last  = repl_last;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

@@ sv/stream_find_replace_top.sv @@
// Path: an accepted byte is held in the pending buffer, then its first result beat in
// the output register; a beat that starts a replacement also waits for ST_REPL.
// Items: one at a time; a new byte is taken only after every result beat of the last
// one is issued. The output register, fed from the buffer shift sequencer, takes one
// beat per cycle while it has room. Reset: synchronous, active high; empties the
// pending buffer, drops any held beat and loads find_length 1, other config regs zero.
`timescale 1ns / 1ps
`include "stream_find_replace_top_defines.svh"

module stream_find_replace_top #(
   parameter int MAX_FIND_LENGTH    = 8,
   parameter int MAX_REPLACE_LENGTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sfr_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                           req_end_of_stream,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_last_in_run
);

   sfr_pkg::sfr_cmd_type    cmd;
   sfr_pkg::sfr_status_type status;

   // Sequence each item
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Buffer, comparators and output register
   sfr_datapath #(
      .MAX_FIND_LENGTH    (MAX_FIND_LENGTH),
      .MAX_REPLACE_LENGTH (MAX_REPLACE_LENGTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_in_run   (rsp_last_in_run),
      .cmd               (cmd),
      .status            (status)
   );

   // Busy in the cycle after taking a beat
   `SFR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // Never shift a beat out of an empty buffer
   `SFR_ASSERT_SAME(a_emit_nonempty, clock, reset, cmd.emit_buf, !status.cnt_zero)
   // No beat is produced while waiting for input
   `SFR_ASSERT_SAME(a_idle_quiet, clock, reset, req_ready, !(cmd.emit_buf || cmd.emit_repl))
   // A beat is only loaded when the output side has room
   `SFR_ASSERT_SAME(a_emit_room, clock, reset, cmd.emit_buf || cmd.emit_repl, status.out_free)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } text_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wen = 1'b0;
   logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sfr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [sfr_pkg::BYTE_W-1:0]     req_data_byte = '0;
   logic                           req_end_of_stream = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [sfr_pkg::BYTE_W-1:0]     rsp_out_byte;
   logic                           rsp_last_in_run;

   stream_find_replace_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_in_run  (rsp_last_in_run)
   );

   always #5 clock = ~clock;

   text_beat_type text_q[$];
   out_beat_type  rewrite_q[$];

   int  mismatch_count = 0;
   int  beats_in = 0;
   int  beats_out = 0;
   int  csr_writes = 0;
   int  idle_cycles = 0;
   bit  req_took = 1'b0;
   bit  no_idle = 1'b0;
   bit  hold_on = 1'b0;
   event stall_go;

   // Shadow of the block: registers and pending buffer
   logic [63:0] sh_pattern;
   logic [3:0]  sh_flen;
   logic [63:0] sh_repl;
   logic [3:0]  sh_rlen;
   logic [63:0] sh_pend;
   int          sh_pend_cnt;

   function automatic int clip_flen(logic [3:0] raw);
      if (raw == 0) return 1;
      if (raw > 8) return 8;
      return int'(raw);
   endfunction

   function automatic bit begins_pattern(logic [63:0] buffer, int n);
      for (int i = 0; i < n; i++)
         if (buffer[i*8 +: 8] != sh_pattern[i*8 +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   // Rewrite one text byte and queue the output beats it causes
   task automatic rewrite_byte(input logic [7:0] d, input logic eos);
      logic [63:0]  buffer;
      logic [7:0]   outs [16];
      out_beat_type ob;
      int           fl;
      int           rl;
      int           cnt;
      int           n;
      fl = clip_flen(sh_flen);
      rl = (sh_rlen > 8) ? 8 : int'(sh_rlen);
      n = 0;
      cnt = sh_pend_cnt;
      if (cnt >= fl) cnt = fl - 1;
      buffer = sh_pend;
      buffer[cnt*8 +: 8] = d;
      cnt++;
      if (cnt == fl && begins_pattern(buffer, cnt)) begin
         for (int i = 0; i < rl; i++) begin
            outs[n] = sh_repl[i*8 +: 8];
            n++;
         end
         cnt = 0;
      end else begin
         while (cnt > 0 && !begins_pattern(buffer, cnt)) begin
            outs[n] = buffer[7:0];
            n++;
            buffer = buffer >> 8;
            cnt--;
         end
      end
      if (eos) begin
         for (int i = 0; i < cnt; i++) begin
            outs[n] = buffer[i*8 +: 8];
            n++;
         end
         cnt = 0;
      end
      sh_pend = buffer;
      sh_pend_cnt = cnt;
      for (int i = 0; i < n; i++) begin
         ob.data = outs[i];
         ob.last = (i == n - 1);
         rewrite_q.push_back(ob);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("MISMATCH %s: got %0h, want %0h (output beat %0d)", what, got, want,
               beats_out);
      mismatch_count++;
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Track register writes, accepted text beats and check output beats
   always @(posedge clock) begin
      out_beat_type want;
      if (reset) begin
         sh_pattern = '0;
         sh_flen = 4'd1;
         sh_repl = '0;
         sh_rlen = 4'd0;
         sh_pend = '0;
         sh_pend_cnt = 0;
         rewrite_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (rewrite_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_out_byte, 8'h00);
            end else begin
               want = rewrite_q.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch("out_byte", rsp_out_byte, want.data);
               if (rsp_last_in_run !== want.last)
                  report_mismatch("last_in_run", {7'b0, rsp_last_in_run}, {7'b0, want.last});
            end
         end
         if (csr_wen) begin
            case (csr_index)
               sfr_pkg::CSR_FIND_PATTERN: begin
                  sh_pattern = csr_wdata;
                  sh_pend_cnt = 0;
               end
               sfr_pkg::CSR_FIND_LENGTH: begin
                  sh_flen = csr_wdata[3:0];
                  sh_pend_cnt = 0;
               end
               sfr_pkg::CSR_REPLACE_TEXT:   sh_repl = csr_wdata;
               sfr_pkg::CSR_REPLACE_LENGTH: sh_rlen = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            beats_in++;
            rewrite_byte(req_data_byte, req_end_of_stream);
            req_took = 1'b1;
         end
      end
   end

   // Drive text beats from the queue, with random gaps
   always @(negedge clock) begin
      text_beat_type it;
      int            req_gap;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_took) begin
         req_took = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (text_q.size() > 0) begin
            it = text_q.pop_front();
            req_data_byte <= it.data;
            req_end_of_stream <= it.eos;
            req_valid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Output side backpressure
   always @(negedge clock) begin
      int rsp_gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap = 0;
      end else if (hold_on) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
   end

   // Long receiver hold-off so the block fills and stalls its input
   always begin
      @(stall_go);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on = 1'b0;
   end

   // Watchdog on cycles without progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wen) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("Timeout: no progress for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [sfr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      csr_writes++;
   endtask

   task automatic push_text(input logic [7:0] d, input logic eos);
      text_beat_type it;
      it.data = d;
      it.eos = eos;
      text_q.push_back(it);
   endtask

   // Wait until every beat is accepted and answered, then let the block settle
   task automatic drain();
      @(posedge clock);
      while (text_q.size() > 0 || req_valid) @(posedge clock);
      while (rewrite_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random text: whole matches, partial prefixes, pattern bytes and noise
   task automatic make_text(input logic [63:0] pattern, input int fl, input int count,
                            input bit end_eos);
      int left;
      int r;
      int plen;
      left = count;
      while (left > 0) begin
         r = $urandom_range(0, 9);
         if (r < 4) plen = fl;
         else if (r < 6) plen = (fl > 1) ? $urandom_range(1, fl - 1) : 1;
         else plen = 0;
         if (plen > left) plen = left;
         if (plen > 0) begin
            for (int i = 0; i < plen; i++) push_text(pattern[i*8 +: 8], 1'b0);
            left -= plen;
         end else if (r < 8) begin
            push_text(pattern[$urandom_range(0, fl - 1)*8 +: 8], 1'b0);
            left--;
         end else begin
            push_text(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            left--;
         end
      end
      if (end_eos) text_q[text_q.size()-1].eos = 1'b1;
   endtask

   initial begin
      logic [63:0] pattern;
      logic [63:0] repl;
      logic [3:0]  flen;
      logic [3:0]  rlen;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: single zero byte deleted, others pass
      push_text(8'h00, 1'b0);
      push_text(8'h01, 1'b0);
      push_text(8'hff, 1'b1);
      drain();

      // Three-byte pattern: match, broken prefix, overlap restart, flush
      csr_write(sfr_pkg::CSR_FIND_PATTERN, 64'h636261);
      csr_write(sfr_pkg::CSR_FIND_LENGTH, 64'd3);
      csr_write(sfr_pkg::CSR_REPLACE_TEXT, 64'h5958);
      csr_write(sfr_pkg::CSR_REPLACE_LENGTH, 64'd2);
      push_text(8'h61, 1'b0); push_text(8'h62, 1'b0); push_text(8'h63, 1'b0);
      push_text(8'h61, 1'b0); push_text(8'h62, 1'b0); push_text(8'h78, 1'b0);
      push_text(8'h61, 1'b0); push_text(8'h61, 1'b0); push_text(8'h62, 1'b0);
      push_text(8'h63, 1'b0);
      push_text(8'h61, 1'b0); push_text(8'h62, 1'b1);
      drain();

      // Oversized replace length, then find length change with bytes pending
      csr_write(sfr_pkg::CSR_FIND_PATTERN, 64'h00ff_ffff);
      csr_write(sfr_pkg::CSR_FIND_LENGTH, 64'd4);
      csr_write(sfr_pkg::CSR_REPLACE_TEXT, {$urandom, $urandom});
      csr_write(sfr_pkg::CSR_REPLACE_LENGTH, 64'd15);
      push_text(8'hff, 1'b0); push_text(8'hff, 1'b0); push_text(8'hff, 1'b0);
      push_text(8'h00, 1'b0);
      push_text(8'hff, 1'b0); push_text(8'hff, 1'b0);
      drain();
      csr_write(sfr_pkg::CSR_FIND_LENGTH, 64'd0);
      push_text(8'h00, 1'b1);
      drain();

      // Random phases over a range of settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin flen = 4'd8;  rlen = 4'd8;  end
            1: begin flen = 4'd1;  rlen = 4'd0;  end
            2: begin flen = 4'd15; rlen = 4'd12; end
            3: begin flen = 4'd0;  rlen = 4'd3;  end
            default: begin
               flen = 4'($urandom_range(1, 8));
               rlen = 4'($urandom_range(0, 9));
            end
         endcase
         pattern = {$urandom, $urandom};
         if ($urandom_range(0, 1) == 1)
            for (int i = 0; i < 8; i++) pattern[i*8 +: 8] = $urandom_range(0, 1) ? 8'h41 : 8'h42;
         repl = {$urandom, $urandom};
         csr_write(sfr_pkg::CSR_FIND_PATTERN, pattern);
         csr_write(sfr_pkg::CSR_FIND_LENGTH, 64'(flen));
         csr_write(sfr_pkg::CSR_REPLACE_TEXT, repl);
         csr_write(sfr_pkg::CSR_REPLACE_LENGTH, 64'(rlen));
         no_idle = (p == 4);
         make_text(pattern, clip_flen(flen), 26, p != 6);
         if (p == 4) begin
            @(posedge clock);
            -> stall_go;
         end
         drain();
      end
      no_idle = 1'b0;

      $display("Covered %0d text beats and %0d output beats", beats_in, beats_out);
      $display("across %0d register writes, pattern lengths 1 to 8 and out-of-range lengths",
               csr_writes);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
